[src/plp_pkg.sv]
// shared types and constants of the position line parser
`default_nettype none

package plp_pkg;

  // default line capacity in bytes
  localparam int unsigned LINE_CAPACITY_DEF = 24;

  // ascii codes
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // largest magnitude a number may reach while digits are read
  localparam logic [19:0] MAG_LIMIT = 20'd32768;
  localparam logic [15:0] MAG_EDGE  = 16'h8000;

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_NODET   = 2'd1,
    KIND_MEAS    = 2'd2
  } line_kind_t;

  typedef enum logic [3:0] {
    SC_START,
    SC_N,
    SC_B,
    SC_BC,
    SC_XSIGN,
    SC_XDIG,
    SC_XCOMMA,
    SC_YSIGN,
    SC_YDIG,
    SC_BAD
  } scan_state_t;

  // judgement of the line as it stands, valid when a line feed is consumed
  typedef struct packed {
    logic               nodet;
    logic               meas;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } verdict_t;

endpackage

`default_nettype wire

[src/plp_if.sv]
// request channels of the position line parser
`default_nettype none

interface plp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] time_ms;

  modport source (output valid, rx_byte, time_ms, input ready);
  modport sink   (input valid, rx_byte, time_ms, output ready);
endinterface

interface plp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         line_kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               data_valid;
  logic               no_detection;
  logic [31:0]        last_update_ms;
  logic [31:0]        frame_count;
  logic [31:0]        measurement_count;

  modport source (output valid, line_kind, pos_x, pos_y, data_valid, no_detection,
                  last_update_ms, frame_count, measurement_count, input ready);
  modport sink   (input valid, line_kind, pos_x, pos_y, data_valid, no_detection,
                  last_update_ms, frame_count, measurement_count, output ready);
endinterface

`default_nettype wire

[src/plp_scan.sv]
// per-byte line scanner: grammar state, length count and number accumulation
`default_nettype none

module plp_scan #(
  parameter int unsigned LINE_CAPACITY = plp_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        rx_byte,
  output plp_pkg::verdict_t      verdict
);

  localparam int unsigned LW = $clog2(LINE_CAPACITY + 1);

  plp_pkg::scan_state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [15:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [15:0]   x_r, x_nxt;

  logic          is_dig;
  logic [19:0]   mag_acc;
  logic          mag_over;
  logic          mag_bad_pos;
  logic [15:0]   mag_signed;

  always_comb begin
    is_dig      = (rx_byte >= plp_pkg::CH_ZERO) && (rx_byte <= plp_pkg::CH_NINE);
    // mag * 10 + digit
    mag_acc     = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0}
                  + {16'd0, rx_byte[3:0] - plp_pkg::CH_ZERO[3:0]};
    mag_over    = mag_acc > plp_pkg::MAG_LIMIT;
    mag_bad_pos = !neg_r && (mag_r == plp_pkg::MAG_EDGE);
    mag_signed  = neg_r ? (16'd0 - mag_r) : mag_r;
  end

  always_comb begin
    verdict.nodet = (state_r == plp_pkg::SC_N);
    verdict.meas  = (state_r == plp_pkg::SC_YDIG) && !mag_bad_pos;
    verdict.x     = x_r;
    verdict.y     = mag_signed;
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    x_nxt     = x_r;
    if (step && (rx_byte != plp_pkg::CH_CR)) begin
      if (rx_byte == plp_pkg::CH_LF) begin
        state_nxt = plp_pkg::SC_START;
        len_nxt   = '0;
      end else if (len_r == LW'(LINE_CAPACITY)) begin
        // full line: byte dropped and the line restarts empty
        state_nxt = plp_pkg::SC_START;
        len_nxt   = '0;
      end else begin
        len_nxt = len_r + LW'(1);
        case (state_r)
          plp_pkg::SC_START: begin
            if (rx_byte == plp_pkg::CH_N) begin
              state_nxt = plp_pkg::SC_N;
            end else if (rx_byte == plp_pkg::CH_B) begin
              state_nxt = plp_pkg::SC_B;
            end else begin
              state_nxt = plp_pkg::SC_BAD;
            end
          end
          plp_pkg::SC_B: begin
            if (rx_byte == plp_pkg::CH_COMMA) begin
              state_nxt = plp_pkg::SC_BC;
              mag_nxt   = '0;
              neg_nxt   = 1'b0;
            end else begin
              state_nxt = plp_pkg::SC_BAD;
            end
          end
          plp_pkg::SC_BC, plp_pkg::SC_XCOMMA: begin
            if (rx_byte == plp_pkg::CH_MINUS) begin
              neg_nxt   = 1'b1;
              state_nxt = (state_r == plp_pkg::SC_BC) ? plp_pkg::SC_XSIGN
                                                      : plp_pkg::SC_YSIGN;
            end else if (is_dig) begin
              mag_nxt   = mag_acc[15:0];
              state_nxt = (state_r == plp_pkg::SC_BC) ? plp_pkg::SC_XDIG
                                                      : plp_pkg::SC_YDIG;
            end else begin
              state_nxt = plp_pkg::SC_BAD;
            end
          end
          plp_pkg::SC_XSIGN, plp_pkg::SC_YSIGN: begin
            if (is_dig) begin
              mag_nxt   = mag_acc[15:0];
              state_nxt = (state_r == plp_pkg::SC_XSIGN) ? plp_pkg::SC_XDIG
                                                         : plp_pkg::SC_YDIG;
            end else begin
              state_nxt = plp_pkg::SC_BAD;
            end
          end
          plp_pkg::SC_XDIG: begin
            if (is_dig) begin
              if (mag_over) begin
                state_nxt = plp_pkg::SC_BAD;
              end else begin
                mag_nxt = mag_acc[15:0];
              end
            end else if ((rx_byte == plp_pkg::CH_COMMA) && !mag_bad_pos) begin
              x_nxt     = mag_signed;
              mag_nxt   = '0;
              neg_nxt   = 1'b0;
              state_nxt = plp_pkg::SC_XCOMMA;
            end else begin
              state_nxt = plp_pkg::SC_BAD;
            end
          end
          plp_pkg::SC_YDIG: begin
            if (is_dig && !mag_over) begin
              mag_nxt = mag_acc[15:0];
            end else begin
              state_nxt = plp_pkg::SC_BAD;
            end
          end
          default: begin
            state_nxt = plp_pkg::SC_BAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plp_pkg::SC_START;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    x_r   <= x_nxt;
  end

endmodule

`default_nettype wire

[src/position_line_parser.sv]
// top level of the position line parser
//
// usage
//   in_ch carries one serial byte per request, with the current millisecond
//   tick. out_ch carries one result request per line feed; other bytes give
//   none. carriage return is skipped anywhere.
//   each byte is scanned as it arrives, so no line text is stored: a small
//   state machine follows the "N" and "B,x,y" forms and builds the numbers
//   digit by digit with a shift-and-add times ten.
// timing
//   one byte per cycle while no line feed waits on a busy out_ch. a byte
//   passes through the input register, and the result of a line feed is
//   loaded into the output register, which drives out_ch, when it is judged.
// reset
//   synchronous, active low. the line restarts empty, held position and
//   counters clear, the held no-detection flag reads 1.
// stall
//   while a result waits on out_ch, bytes other than line feed still flow in;
//   a second line feed waits in the input register until the result is taken.
`default_nettype none

module position_line_parser #(
  parameter int unsigned LINE_CAPACITY = plp_pkg::LINE_CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  plp_in_if.sink      in_ch,
  plp_out_if.source   out_ch
);

  // input register
  logic        s1_v_r;
  logic [7:0]  s1_byte_r;
  logic [31:0] s1_time_r;

  // held state
  logic signed [15:0] held_x_r, held_x_nxt;
  logic signed [15:0] held_y_r, held_y_nxt;
  logic               valid_flag_r, valid_flag_nxt;
  logic               nodet_r, nodet_nxt;
  logic [31:0]        stamp_r, stamp_nxt;
  logic [31:0]        frames_r, frames_nxt;
  logic [31:0]        measures_r, measures_nxt;

  // result register
  logic               out_v_r;
  plp_pkg::line_kind_t out_kind_r, kind_nxt;
  logic signed [15:0] out_x_r;
  logic signed [15:0] out_y_r;
  logic               out_valid_flag_r;
  logic               out_nodet_r;
  logic [31:0]        out_stamp_r;
  logic [31:0]        out_frames_r;
  logic [31:0]        out_measures_r;

  logic              is_lf;
  logic              out_free;
  logic              step;
  logic              judge;
  plp_pkg::verdict_t verdict;

  // only a line feed needs the result register; other bytes never wait on it
  assign is_lf    = (s1_byte_r == plp_pkg::CH_LF);
  assign out_free = !out_v_r || out_ch.ready;
  assign step     = s1_v_r && (!is_lf || out_free);
  assign judge    = step && is_lf;

  assign in_ch.ready = !s1_v_r || step;

  plp_scan #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte_r),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_time_r <= in_ch.time_ms;
    end
  end

  // judge the line and update the held values
  always_comb begin
    held_x_nxt     = held_x_r;
    held_y_nxt     = held_y_r;
    valid_flag_nxt = valid_flag_r;
    nodet_nxt      = nodet_r;
    stamp_nxt      = stamp_r;
    frames_nxt     = frames_r;
    measures_nxt   = measures_r;
    kind_nxt       = plp_pkg::KIND_IGNORED;
    if (verdict.nodet) begin
      kind_nxt   = plp_pkg::KIND_NODET;
      nodet_nxt  = 1'b1;
      frames_nxt = frames_r + 32'd1;
    end else if (verdict.meas) begin
      kind_nxt       = plp_pkg::KIND_MEAS;
      held_x_nxt     = verdict.x;
      held_y_nxt     = verdict.y;
      stamp_nxt      = s1_time_r;
      valid_flag_nxt = 1'b1;
      nodet_nxt      = 1'b0;
      frames_nxt     = frames_r + 32'd1;
      measures_nxt   = measures_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r     <= '0;
      held_y_r     <= '0;
      valid_flag_r <= 1'b0;
      nodet_r      <= 1'b1;
      stamp_r      <= '0;
      frames_r     <= '0;
      measures_r   <= '0;
    end else if (judge) begin
      held_x_r     <= held_x_nxt;
      held_y_r     <= held_y_nxt;
      valid_flag_r <= valid_flag_nxt;
      nodet_r      <= nodet_nxt;
      stamp_r      <= stamp_nxt;
      frames_r     <= frames_nxt;
      measures_r   <= measures_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (judge) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (judge) begin
      out_kind_r       <= kind_nxt;
      out_x_r          <= held_x_nxt;
      out_y_r          <= held_y_nxt;
      out_valid_flag_r <= valid_flag_nxt;
      out_nodet_r      <= nodet_nxt;
      out_stamp_r      <= stamp_nxt;
      out_frames_r     <= frames_nxt;
      out_measures_r   <= measures_nxt;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.line_kind         = out_kind_r;
  assign out_ch.pos_x             = out_x_r;
  assign out_ch.pos_y             = out_y_r;
  assign out_ch.data_valid        = out_valid_flag_r;
  assign out_ch.no_detection      = out_nodet_r;
  assign out_ch.last_update_ms    = out_stamp_r;
  assign out_ch.frame_count       = out_frames_r;
  assign out_ch.measurement_count = out_measures_r;

endmodule

`default_nettype wire
